@@ rtl/core/ortrk_pkg.sv @@
// ----------------------------------------------------------------------------
// ortrk_pkg
// Types and codes shared by the outstanding request tracker.
// ----------------------------------------------------------------------------
package ortrk_pkg;

  localparam int ID_W      = 16;
  localparam int HDL_W     = 16;
  localparam int STAMP_W   = 32;
  localparam int TMO_W     = 16;
  localparam int MAX_RES   = 16;
  localparam int NRES_W    = $clog2(MAX_RES + 1);
  localparam logic [ID_W-1:0] ID_RESET  = 16'd1;
  localparam logic [TMO_W-1:0] TMO_RESET = 16'd10;

  typedef enum logic [2:0] {
    CMD_ADD     = 3'd0,
    CMD_TAKE    = 3'd1,
    CMD_MARK    = 3'd2,
    CMD_RESP    = 3'd3,
    CMD_LOOKUP  = 3'd4,
    CMD_TICK    = 3'd5,
    CMD_SWEEP   = 3'd6,
    CMD_RELEASE = 3'd7
  } cmd_t;

  typedef enum logic [1:0] {
    KIND_REPLY   = 2'd0,
    KIND_COMPL   = 2'd1,
    KIND_TIMEOUT = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    STAT_OK       = 3'd0,
    STAT_FULL     = 3'd1,
    STAT_NOTFOUND = 3'd2,
    STAT_WRONG    = 3'd3,
    STAT_NONE     = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    SLOT_QUEUED  = 2'd0,
    SLOT_PENDING = 2'd1,
    SLOT_DONE    = 2'd2,
    SLOT_TIMEOUT = 2'd3
  } slot_st_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } fsm_t;

  typedef struct packed {
    kind_t            kind;
    status_t          status;
    logic [ID_W-1:0]  id;
    logic [HDL_W-1:0] handle;
    logic [ID_W-1:0]  next_id;
    logic             last;
  } res_t;

  function automatic res_t mk_res(kind_t k, status_t s, logic [ID_W-1:0] id,
                                  logic [HDL_W-1:0] h, logic [ID_W-1:0] nid,
                                  logic lst);
    res_t r;
    r.kind    = k;
    r.status  = s;
    r.id      = id;
    r.handle  = h;
    r.next_id = nid;
    r.last    = lst;
    return r;
  endfunction

endpackage

@@ rtl/core/outstanding_request_tracker_unit.sv @@
// ----------------------------------------------------------------------------
// outstanding_request_tracker_unit
// Slot table that follows requests from queued to pending to completed or
// timed out, scanned one slot per cycle by a shared compare unit.
// ----------------------------------------------------------------------------
//  channel   ports                                   handshake
//  command   in_cmd, in_req_id, in_payload           start && !busy
//  result    out_kind .. out_last                    out_strobe, one cycle
//  config    cfg_wr_data                             cfg_wr_en
//
//  tick goes straight to the finish state; other commands first scan, one
//  slot read per cycle through the table's single read port, then finish:
//  reply, and update the chosen slot if the command changes one. results
//  are registered and appear in the cycle after they are decided; a sweep
//  can put out one timeout beat per cycle of its scan. reset is synchronous;
//  valid bits clear at once, no memory clearing pass. results never stall.
// ----------------------------------------------------------------------------
module outstanding_request_tracker_unit
  import ortrk_pkg::*;
#(
  parameter int SLOTS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [2:0]        in_cmd,
  input  logic [ID_W-1:0]   in_req_id,
  input  logic [HDL_W-1:0]  in_payload,
  output logic              out_strobe,
  output logic [1:0]        out_kind,
  output logic [2:0]        out_status,
  output logic [ID_W-1:0]   out_id_out,
  output logic [HDL_W-1:0]  out_handle_out,
  output logic [ID_W-1:0]   out_next_id_now,
  output logic              out_last,
  input  logic              cfg_wr_en,
  input  logic [TMO_W-1:0]  cfg_wr_data
);

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W = $clog2(SLOTS + 1);
  localparam logic [CNT_W-1:0] CNT_END = CNT_W'(SLOTS);

  // slot memories
  logic [ID_W-1:0]    mem_id    [SLOTS];
  slot_st_t           mem_st    [SLOTS];
  logic [STAMP_W-1:0] mem_stamp [SLOTS];
  logic [HDL_W-1:0]   mem_hdl   [SLOTS];

  logic [ID_W-1:0]    rd_id_r;
  slot_st_t           rd_st_r;
  logic [STAMP_W-1:0] rd_stamp_r;
  logic [HDL_W-1:0]   rd_hdl_r;

  fsm_t               state_r, state_nxt;
  cmd_t               cmd_r, cmd_nxt;
  logic [ID_W-1:0]    rid_r, rid_nxt;
  logic [HDL_W-1:0]   pay_r, pay_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               ev_v_r, ev_v_nxt;
  logic [IDX_W-1:0]   ev_idx_r, ev_idx_nxt;
  logic               hit_r, hit_nxt;
  logic [IDX_W-1:0]   hit_idx_r, hit_idx_nxt;
  slot_st_t           hit_st_r, hit_st_nxt;
  logic [ID_W-1:0]    hit_id_r, hit_id_nxt;
  logic [HDL_W-1:0]   hit_hdl_r, hit_hdl_nxt;
  logic               aux_r, aux_nxt;
  logic [NRES_W-1:0]  n_r, n_nxt;
  logic               hold_v_r, hold_v_nxt;
  logic [ID_W-1:0]    hold_id_r, hold_id_nxt;
  logic [SLOTS-1:0]   valid_r, valid_nxt;
  logic [ID_W-1:0]    id_cnt_r, id_cnt_nxt;
  logic [STAMP_W-1:0] time_r, time_nxt;
  logic [TMO_W-1:0]   tmo_r;
  logic               out_strobe_r, out_strobe_nxt;
  res_t               out_r, out_nxt;

  // memory write controls
  logic               wr_add;
  logic               wr_st_en;
  logic               wr_stamp_en;
  slot_st_t           wr_st;
  logic [IDX_W-1:0]   wr_idx;

  // shared compare unit
  logic               ev_slot_v;
  logic               id_eq;
  logic [STAMP_W-1:0] age;
  logic               overdue;
  logic               prim;

  assign ev_slot_v = valid_r[ev_idx_r];
  assign id_eq     = (rd_id_r == rid_r);
  assign age       = time_r - rd_stamp_r;
  assign overdue   = age > {{(STAMP_W-TMO_W){1'b0}}, tmo_r};

  always_comb begin
    case (cmd_r)
      CMD_ADD:  prim = !ev_slot_v;
      CMD_TAKE: prim = ev_slot_v && (rd_st_r == SLOT_QUEUED);
      CMD_RESP: prim = ev_slot_v && id_eq && (rd_st_r == SLOT_PENDING);
      default:  prim = ev_slot_v && id_eq;
    endcase
  end

  assign busy = (state_r != ST_IDLE);

  always_comb begin
    state_nxt      = state_r;
    cmd_nxt        = cmd_r;
    rid_nxt        = rid_r;
    pay_nxt        = pay_r;
    cnt_nxt        = cnt_r;
    ev_v_nxt       = 1'b0;
    ev_idx_nxt     = ev_idx_r;
    hit_nxt        = hit_r;
    hit_idx_nxt    = hit_idx_r;
    hit_st_nxt     = hit_st_r;
    hit_id_nxt     = hit_id_r;
    hit_hdl_nxt    = hit_hdl_r;
    aux_nxt        = aux_r;
    n_nxt          = n_r;
    hold_v_nxt     = hold_v_r;
    hold_id_nxt    = hold_id_r;
    valid_nxt      = valid_r;
    id_cnt_nxt     = id_cnt_r;
    time_nxt       = time_r;
    out_strobe_nxt = 1'b0;
    out_nxt        = out_r;
    wr_add         = 1'b0;
    wr_st_en       = 1'b0;
    wr_stamp_en    = 1'b0;
    wr_st          = SLOT_QUEUED;
    wr_idx         = hit_idx_r;

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd_nxt    = cmd_t'(in_cmd);
          rid_nxt    = in_req_id;
          pay_nxt    = in_payload;
          cnt_nxt    = '0;
          hit_nxt    = 1'b0;
          aux_nxt    = 1'b0;
          n_nxt      = '0;
          hold_v_nxt = 1'b0;
          state_nxt  = (cmd_t'(in_cmd) == CMD_TICK) ? ST_DONE : ST_SCAN;
        end
      end

      ST_SCAN: begin
        if (cnt_r != CNT_END) begin
          ev_v_nxt   = 1'b1;
          ev_idx_nxt = cnt_r[IDX_W-1:0];
          cnt_nxt    = cnt_r + 1'b1;
        end else begin
          state_nxt = ST_DONE;
        end
        if (ev_v_r) begin
          if (!hit_r && prim) begin
            hit_nxt     = 1'b1;
            hit_idx_nxt = ev_idx_r;
            hit_st_nxt  = rd_st_r;
            hit_id_nxt  = rd_id_r;
            hit_hdl_nxt = rd_hdl_r;
          end
          if (ev_slot_v && id_eq) begin
            aux_nxt = 1'b1;
          end
          // sweep: hold back the newest timeout so the final one carries last
          if (cmd_r == CMD_SWEEP && ev_slot_v && rd_st_r == SLOT_PENDING && overdue
              && n_r < NRES_W'(MAX_RES)) begin
            wr_st_en    = 1'b1;
            wr_st       = SLOT_TIMEOUT;
            wr_idx      = ev_idx_r;
            n_nxt       = n_r + 1'b1;
            hold_v_nxt  = 1'b1;
            hold_id_nxt = rd_id_r;
            if (hold_v_r) begin
              out_strobe_nxt = 1'b1;
              out_nxt = mk_res(KIND_TIMEOUT, STAT_OK, hold_id_r, '0, id_cnt_r, 1'b0);
            end
          end
        end
      end

      ST_DONE: begin
        state_nxt      = ST_IDLE;
        out_strobe_nxt = 1'b1;
        case (cmd_r)
          CMD_ADD: begin
            if (hit_r) begin
              id_cnt_nxt           = id_cnt_r + 1'b1;
              valid_nxt[hit_idx_r] = 1'b1;
              wr_add               = 1'b1;
              wr_st_en             = 1'b1;
              wr_stamp_en          = 1'b1;
              wr_st                = SLOT_QUEUED;
              out_nxt = mk_res(KIND_REPLY, STAT_OK, id_cnt_r, '0, id_cnt_r + 1'b1, 1'b1);
            end else begin
              out_nxt = mk_res(KIND_REPLY, STAT_FULL, '0, '0, id_cnt_r, 1'b1);
            end
          end
          CMD_TAKE: begin
            if (hit_r) out_nxt = mk_res(KIND_REPLY, STAT_OK, hit_id_r, hit_hdl_r,
                                        id_cnt_r, 1'b1);
            else       out_nxt = mk_res(KIND_REPLY, STAT_NONE, '0, '0, id_cnt_r, 1'b1);
          end
          CMD_MARK: begin
            if (!hit_r) begin
              out_nxt = mk_res(KIND_REPLY, STAT_NOTFOUND, '0, '0, id_cnt_r, 1'b1);
            end else if (hit_st_r != SLOT_QUEUED) begin
              out_nxt = mk_res(KIND_REPLY, STAT_WRONG, '0, '0, id_cnt_r, 1'b1);
            end else begin
              wr_st_en    = 1'b1;
              wr_stamp_en = 1'b1;
              wr_st       = SLOT_PENDING;
              out_nxt = mk_res(KIND_REPLY, STAT_OK, rid_r, '0, id_cnt_r, 1'b1);
            end
          end
          CMD_RESP: begin
            if (hit_r) begin
              wr_st_en = 1'b1;
              wr_st    = SLOT_DONE;
              out_nxt  = mk_res(KIND_COMPL, STAT_OK, rid_r, pay_r, id_cnt_r, 1'b1);
            end else if (aux_r) begin
              out_nxt = mk_res(KIND_REPLY, STAT_WRONG, '0, '0, id_cnt_r, 1'b1);
            end else begin
              out_nxt = mk_res(KIND_REPLY, STAT_NOTFOUND, '0, '0, id_cnt_r, 1'b1);
            end
          end
          CMD_LOOKUP: begin
            if (hit_r) out_nxt = mk_res(KIND_REPLY, STAT_OK, rid_r, hit_hdl_r,
                                        id_cnt_r, 1'b1);
            else       out_nxt = mk_res(KIND_REPLY, STAT_NOTFOUND, '0, '0, id_cnt_r, 1'b1);
          end
          CMD_TICK: begin
            time_nxt = time_r + 1'b1;
            out_nxt  = mk_res(KIND_REPLY, STAT_OK, '0, '0, id_cnt_r, 1'b1);
          end
          CMD_SWEEP: begin
            if (hold_v_r) out_nxt = mk_res(KIND_TIMEOUT, STAT_OK, hold_id_r, '0,
                                           id_cnt_r, 1'b1);
            else          out_nxt = mk_res(KIND_REPLY, STAT_NONE, '0, '0, id_cnt_r, 1'b1);
          end
          default: begin
            if (hit_r) begin
              valid_nxt[hit_idx_r] = 1'b0;
              out_nxt = mk_res(KIND_REPLY, STAT_OK, rid_r, '0, id_cnt_r, 1'b1);
            end else begin
              out_nxt = mk_res(KIND_REPLY, STAT_NOTFOUND, '0, '0, id_cnt_r, 1'b1);
            end
          end
        endcase
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // slot table: one write port, one registered read port driven by the scan
  always_ff @(posedge clk) begin
    if (wr_add) begin
      mem_id[wr_idx]  <= id_cnt_r;
      mem_hdl[wr_idx] <= pay_r;
    end
    if (wr_st_en) begin
      mem_st[wr_idx] <= wr_st;
    end
    if (wr_stamp_en) begin
      mem_stamp[wr_idx] <= time_r;
    end
    rd_id_r    <= mem_id[cnt_r[IDX_W-1:0]];
    rd_st_r    <= mem_st[cnt_r[IDX_W-1:0]];
    rd_stamp_r <= mem_stamp[cnt_r[IDX_W-1:0]];
    rd_hdl_r   <= mem_hdl[cnt_r[IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      ev_v_r       <= 1'b0;
      hit_r        <= 1'b0;
      aux_r        <= 1'b0;
      n_r          <= '0;
      hold_v_r     <= 1'b0;
      valid_r      <= '0;
      id_cnt_r     <= ID_RESET;
      time_r       <= '0;
      tmo_r        <= TMO_RESET;
      out_strobe_r <= 1'b0;
      cnt_r        <= '0;
    end else begin
      state_r      <= state_nxt;
      ev_v_r       <= ev_v_nxt;
      hit_r        <= hit_nxt;
      aux_r        <= aux_nxt;
      n_r          <= n_nxt;
      hold_v_r     <= hold_v_nxt;
      valid_r      <= valid_nxt;
      id_cnt_r     <= id_cnt_nxt;
      time_r       <= time_nxt;
      out_strobe_r <= out_strobe_nxt;
      cnt_r        <= cnt_nxt;
      if (cfg_wr_en) begin
        tmo_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    cmd_r       <= cmd_nxt;
    rid_r       <= rid_nxt;
    pay_r       <= pay_nxt;
    ev_idx_r    <= ev_idx_nxt;
    hit_idx_r   <= hit_idx_nxt;
    hit_st_r    <= hit_st_nxt;
    hit_id_r    <= hit_id_nxt;
    hit_hdl_r   <= hit_hdl_nxt;
    hold_id_r   <= hold_id_nxt;
    out_r       <= out_nxt;
  end

  assign out_strobe      = out_strobe_r;
  assign out_kind        = out_r.kind;
  assign out_status      = out_r.status;
  assign out_id_out      = out_r.id;
  assign out_handle_out  = out_r.handle;
  assign out_next_id_now = out_r.next_id;
  assign out_last        = out_r.last;

  // a command beat always leaves the block busy on the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted command did not start");

  // only a sweep gives more than one beat, and those are timeouts
  a_multi_timeout: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_last) |-> (out_kind == KIND_TIMEOUT))
    else $error("non-final beat that is not a timeout");

  // sweep never marks more slots than the result limit
  a_sweep_limit: assert property (@(posedge clk) disable iff (!rst_n)
    n_r <= NRES_W'(MAX_RES))
    else $error("sweep exceeded result limit");

  // the final beat of a command is produced as the block returns to idle
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_last) |-> !busy)
    else $error("final beat while still busy");

endmodule
